@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked implication with an explicit antecedent and consequent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

@@ hdl/lrupl_pkg.sv @@
`default_nettype none

package lrupl_pkg;

	localparam int CAPACITY  = 64;
	localparam int PAGE_BITS = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		CMD_SEARCH     = 2'd0,
		CMD_ATTACH     = 2'd1,
		CMD_EVICT_LRU  = 2'd2,
		CMD_EVICT_PAGE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] page;
		logic        dirty;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic        evicted_valid;
		logic [31:0] evicted_page;
		logic        evicted_dirty;
		stat_t       status;
		logic [6:0]  occupancy;
	} out_item_t;

	// One command presented to the list for the current cycle.
	typedef struct packed {
		logic                 go;
		cmd_t                 command;
		logic [PAGE_BITS-1:0] page;
		logic                 dirty;
	} lrupl_req_t;

endpackage

`default_nettype wire

@@ hdl/lrupl_list.sv @@
`default_nettype none

module lrupl_list import lrupl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lrupl_req_t op,
	output out_item_t  result
);

	logic [PAGE_BITS-1:0] page_q [CAPACITY];
	logic [CAPACITY-1:0]  dirty_q;
	logic [CAPACITY-1:0]  valid_q;
	logic [CNT_W-1:0]     count_q;

	logic [CAPACITY-1:0]  match;
	logic [CAPACITY-1:0]  hit_tail;
	logic [CAPACITY-1:0]  top_valid;
	logic [CAPACITY-1:0]  first_free;
	logic [CAPACITY-1:0]  shift_en;
	logic [CAPACITY-1:0]  wr_en;
	logic [CAPACITY-1:0]  valid_next;
	logic [CNT_W-1:0]     count_next;
	logic                 found;
	logic                 empty;
	logic                 full;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = valid_q[i] && (page_q[i] == op.page);
		end
	end

	// The list never holds a page twice, so match is one-hot or empty and
	// the subtraction marks the hit position and everything above it.
	assign found      = |match;
	assign hit_tail   = found ? ~(match - CAPACITY'(1)) : '0;
	assign top_valid  = valid_q & ~(valid_q >> 1);
	assign first_free = ~valid_q & {valid_q[CAPACITY-2:0], 1'b1};
	assign empty      = (count_q == '0);
	assign full       = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		shift_en   = '0;
		wr_en      = '0;
		valid_next = valid_q;
		count_next = count_q;
		result     = '0;
		result.status = STAT_OK;
		unique case (op.command)
			CMD_SEARCH: begin
				result.found = found;
			end
			CMD_ATTACH: begin
				result.found = found;
				if (found) begin
					// Close the gap and rewrite the page at the most recent end.
					shift_en = hit_tail;
					wr_en    = top_valid;
				end else if (full) begin
					result.status = STAT_FULL;
				end else begin
					wr_en      = first_free;
					valid_next = valid_q | first_free;
					count_next = count_q + CNT_W'(1);
				end
			end
			CMD_EVICT_LRU: begin
				if (empty) begin
					result.status = STAT_EMPTY;
				end else begin
					result.evicted_valid = 1'b1;
					result.evicted_page  = 32'(page_q[0]);
					result.evicted_dirty = dirty_q[0];
					shift_en   = '1;
					valid_next = valid_q >> 1;
					count_next = count_q - CNT_W'(1);
				end
			end
			CMD_EVICT_PAGE: begin
				if (!found) begin
					result.status = STAT_EMPTY;
				end else begin
					result.found         = 1'b1;
					result.evicted_valid = 1'b1;
					result.evicted_page  = 32'(op.page);
					result.evicted_dirty = |(match & dirty_q);
					shift_en   = hit_tail;
					valid_next = valid_q >> 1;
					count_next = count_q - CNT_W'(1);
				end
			end
		endcase
		result.occupancy = 7'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (op.go) begin
			valid_q <= valid_next;
			count_q <= count_next;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [PAGE_BITS-1:0] page_up;
		logic                 dirty_up;

		if (i < CAPACITY - 1) begin : g_inner
			assign page_up  = page_q[i+1];
			assign dirty_up = dirty_q[i+1];
		end else begin : g_last
			assign page_up  = page_q[i];
			assign dirty_up = dirty_q[i];
		end

		always_ff @(posedge clk) begin
			if (op.go) begin
				if (wr_en[i]) begin
					page_q[i]  <= op.page;
					dirty_q[i] <= op.dirty;
				end else if (shift_en[i]) begin
					page_q[i]  <= page_up;
					dirty_q[i] <= dirty_up;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/lru_ordered_page_list_core.sv @@
// LRU-ordered page list: up to 64 pages with dirty marks, held in recency order
// from the oldest entry at position 0 to the newest at the top. It takes one
// command (search, attach at the most recent end, evict the oldest, evict a
// named page) every clock cycle and returns one response per command. The
// response is registered: the input register feeds the parallel compare of
// all 64 entries and the shift of the list, and the outcome is captured in
// the response register once the output is free.
// A present page that is attached again moves to the most recent end and takes
// the new dirty mark. Either side may stall at any time; while a response
// waits, one further request can be taken into the input register, and later
// request transfers wait until the response has been taken.
`default_nettype none

module lru_ordered_page_list_core import lrupl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      request_valid,
	output logic      request_stall,
	input  in_item_t  request,
	output logic      response_valid,
	input  logic      response_stall,
	output out_item_t response
);

	logic       req_valid_s1;
	in_item_t   req_s1;
	logic       response_valid_q;
	out_item_t  response_q;
	logic       out_free;
	logic       take;
	lrupl_req_t op;
	out_item_t  result;

	assign out_free      = !response_valid_q || !response_stall;
	assign take          = req_valid_s1 && out_free;
	assign request_stall = req_valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1     <= 1'b0;
			response_valid_q <= 1'b0;
		end else begin
			if (!request_stall) begin
				req_valid_s1 <= request_valid;
			end
			if (out_free) begin
				response_valid_q <= req_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request_valid && !request_stall) begin
			req_s1 <= request;
		end
		if (take) begin
			response_q <= result;
		end
	end

	assign op.go      = take;
	assign op.command = req_s1.command;
	assign op.page    = PAGE_BITS'(req_s1.page);
	assign op.dirty   = req_s1.dirty;

	lrupl_list u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.result (result)
	);

	assign response_valid = response_valid_q;
	assign response       = response_q;

endmodule

`default_nettype wire

@@ hdl/lrupl_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module lrupl_checker import lrupl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      request_valid,
	input logic      request_stall,
	input in_item_t  request,
	input logic      response_valid,
	input logic      response_stall,
	input out_item_t response
);

	`ASSERT_CLK(a_resp_held, clk, arst_n, response_valid && response_stall |=> response_valid)
	`ASSERT_CLK(a_resp_stable, clk, arst_n, response_valid && response_stall |=> $stable(response))
	`ASSERT_IMPLIES(a_occ_bound, clk, arst_n, response_valid, response.occupancy <= 7'(CAPACITY))
	`ASSERT_IMPLIES(a_evict_ok, clk, arst_n, response_valid && response.evicted_valid, response.status == STAT_OK)

endmodule

bind lru_ordered_page_list_core lrupl_checker u_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
	import lrupl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1100;
	localparam int POOL_SIZE    = 80;
	localparam int QUIET_FROM   = 500;
	localparam int QUIET_TO     = 700;

	localparam logic [31:0] PAGE_MASK = (PAGE_BITS >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << PAGE_BITS) - 32'd1);

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      request_valid = 1'b0;
	logic      request_stall;
	in_item_t  request = '0;
	logic      response_valid;
	logic      response_stall = 1'b0;
	out_item_t response;

	lru_ordered_page_list_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.request_valid  (request_valid),
		.request_stall  (request_stall),
		.request        (request),
		.response_valid (response_valid),
		.response_stall (response_stall),
		.response       (response)
	);

	always #2 clk = ~clk;

	// Shadow copy of the list, oldest entry at index 0.
	logic [31:0] held_page [CAPACITY];
	logic        held_dirty [CAPACITY];
	int          held_count = 0;

	in_item_t  command_backlog [$];
	out_item_t predicted_responses [$];
	out_item_t want;

	int failures = 0;
	int commands_sent = 0;
	int responses_checked = 0;
	int evictions = 0;
	int refused_full = 0;
	int nothing_to_evict = 0;
	int moved_to_mru = 0;
	int peak_occupancy = 0;

	function automatic void list_remove(int pos);
		for (int i = pos; i + 1 < held_count; i++) begin
			held_page[i]  = held_page[i + 1];
			held_dirty[i] = held_dirty[i + 1];
		end
		held_count--;
	endfunction

	function automatic void list_append(logic [31:0] pg, logic d);
		held_page[held_count]  = pg;
		held_dirty[held_count] = d;
		held_count++;
		if (held_count > peak_occupancy)
			peak_occupancy = held_count;
	endfunction

	function automatic out_item_t list_apply(in_item_t c);
		out_item_t   r;
		int          pos;
		logic [31:0] pg;
		r   = '0;
		pos = -1;
		pg  = c.page & PAGE_MASK;
		r.status = STAT_OK;
		for (int i = 0; i < held_count; i++)
			if (pos < 0 && held_page[i] == pg)
				pos = i;
		case (c.command)
			CMD_SEARCH: r.found = (pos >= 0);
			CMD_ATTACH: begin
				r.found = (pos >= 0);
				if (pos >= 0) begin
					list_remove(pos);
					list_append(pg, c.dirty);
					moved_to_mru++;
				end else if (held_count >= CAPACITY) begin
					r.status = STAT_FULL;
					refused_full++;
				end else begin
					list_append(pg, c.dirty);
				end
			end
			CMD_EVICT_LRU: begin
				if (held_count == 0) begin
					r.status = STAT_EMPTY;
					nothing_to_evict++;
				end else begin
					r.evicted_valid = 1'b1;
					r.evicted_page  = held_page[0];
					r.evicted_dirty = held_dirty[0];
					list_remove(0);
					evictions++;
				end
			end
			default: begin
				if (pos < 0) begin
					r.status = STAT_EMPTY;
					nothing_to_evict++;
				end else begin
					r.found         = 1'b1;
					r.evicted_valid = 1'b1;
					r.evicted_page  = held_page[pos];
					r.evicted_dirty = held_dirty[pos];
					list_remove(pos);
					evictions++;
				end
			end
		endcase
		r.occupancy = held_count[6:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			failures++;
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
		end
	endfunction

	// Random idling, switched off for one long stretch of the run.
	function automatic logic take_break(int n);
		if (n >= QUIET_FROM && n < QUIET_TO)
			return 1'b0;
		return ($urandom_range(99) < 16);
	endfunction

	function automatic in_item_t make_cmd(cmd_t c, logic [31:0] pg, logic d);
		in_item_t it;
		it.command = c;
		it.page    = pg;
		it.dirty   = d;
		return it;
	endfunction

	// Driver: a new item is presented only once the previous one has been transferred.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_valid <= 1'b0;
			request       <= '0;
		end else begin
			if (request_valid && !request_stall) begin
				predicted_responses.push_back(list_apply(request));
				commands_sent++;
			end
			if (!request_valid || !request_stall) begin
				if (command_backlog.size() != 0 && !take_break(commands_sent)) begin
					request_valid <= 1'b1;
					request       <= command_backlog.pop_front();
				end else begin
					request_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every response transfer is matched against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response_stall <= 1'b0;
		end else begin
			if (response_valid && !response_stall) begin
				if (predicted_responses.size() == 0) begin
					failures++;
					$error("response transfer with no command outstanding");
				end else begin
					want = predicted_responses.pop_front();
					check_field("found", 32'(want.found), 32'(response.found));
					check_field("evicted_valid", 32'(want.evicted_valid),
						32'(response.evicted_valid));
					check_field("evicted_page", want.evicted_page, response.evicted_page);
					check_field("evicted_dirty", 32'(want.evicted_dirty),
						32'(response.evicted_dirty));
					check_field("status", 32'(want.status), 32'(response.status));
					check_field("occupancy", 32'(want.occupancy), 32'(response.occupancy));
				end
				responses_checked++;
			end
			response_stall <= take_break(responses_checked);
		end
	end

	initial begin
		logic [31:0] pool [POOL_SIZE];
		int          n_rand;
		int          phase;
		int          kind;
		int          len;
		int          k;
		int          roll;
		cmd_t        c;
		n_rand = 0;
		phase  = 0;

		// Directed opening: empty list, extreme pages, re-attach and absent pages.
		command_backlog.push_back(make_cmd(CMD_EVICT_LRU, 32'h0, 1'b0));
		command_backlog.push_back(make_cmd(CMD_EVICT_PAGE, 32'h0, 1'b1));
		command_backlog.push_back(make_cmd(CMD_SEARCH, 32'h0, 1'b0));
		command_backlog.push_back(make_cmd(CMD_ATTACH, 32'h0, 1'b1));
		command_backlog.push_back(make_cmd(CMD_ATTACH, 32'hFFFF_FFFF, 1'b0));
		command_backlog.push_back(make_cmd(CMD_ATTACH, 32'h5555_5555, 1'b1));
		command_backlog.push_back(make_cmd(CMD_ATTACH, 32'hAAAA_AAAA, 1'b0));
		command_backlog.push_back(make_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 1'b1));
		command_backlog.push_back(make_cmd(CMD_SEARCH, 32'h1234_5678, 1'b0));
		command_backlog.push_back(make_cmd(CMD_ATTACH, 32'h0, 1'b0));
		command_backlog.push_back(make_cmd(CMD_ATTACH, 32'hAAAA_AAAA, 1'b1));
		command_backlog.push_back(make_cmd(CMD_EVICT_PAGE, 32'hFFFF_FFFF, 1'b0));
		command_backlog.push_back(make_cmd(CMD_EVICT_PAGE, 32'h1234_5678, 1'b1));
		command_backlog.push_back(make_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 1'b0));
		command_backlog.push_back(make_cmd(CMD_EVICT_LRU, 32'hFFFF_FFFF, 1'b1));
		command_backlog.push_back(make_cmd(CMD_EVICT_LRU, 32'h0, 1'b0));
		command_backlog.push_back(make_cmd(CMD_EVICT_PAGE, 32'hAAAA_AAAA, 1'b0));
		command_backlog.push_back(make_cmd(CMD_EVICT_LRU, 32'h0, 1'b0));
		command_backlog.push_back(make_cmd(CMD_EVICT_PAGE, 32'hAAAA_AAAA, 1'b1));

		// Random part in phases that fill the list to capacity, churn it and drain it.
		// Pages come mostly from a small pool so that hits and duplicates are common.
		while (n_rand < RANDOM_ITEMS) begin
			kind = phase % 3;
			if (kind == 0) begin
				for (k = 0; k < POOL_SIZE; k++)
					pool[k] = $urandom();
				pool[0] = 32'h0;
				pool[1] = 32'hFFFF_FFFF;
				len = $urandom_range(220, 150);
			end else begin
				len = $urandom_range(160, 80);
			end
			for (k = 0; k < len && n_rand < RANDOM_ITEMS; k++) begin
				if ($urandom_range(9) == 0) begin
					command_backlog.push_back(make_cmd(cmd_t'($urandom_range(3)),
						$urandom(), 1'($urandom_range(1))));
				end else begin
					roll = $urandom_range(99);
					case (kind)
						0: c = (roll < 12) ? CMD_SEARCH : (roll < 92) ? CMD_ATTACH :
							(roll < 96) ? CMD_EVICT_LRU : CMD_EVICT_PAGE;
						1: c = (roll < 25) ? CMD_SEARCH : (roll < 55) ? CMD_ATTACH :
							(roll < 75) ? CMD_EVICT_LRU : CMD_EVICT_PAGE;
						default: c = (roll < 10) ? CMD_SEARCH : (roll < 20) ? CMD_ATTACH :
							(roll < 60) ? CMD_EVICT_LRU : CMD_EVICT_PAGE;
					endcase
					command_backlog.push_back(make_cmd(c, pool[$urandom_range(POOL_SIZE - 1)],
						1'($urandom_range(1))));
				end
				n_rand++;
			end
			phase++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (command_backlog.size() != 0 || request_valid || predicted_responses.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d commands checked over %0d phases, list peaked at %0d of %0d entries",
			responses_checked, phase, peak_occupancy, CAPACITY);
		$display("%0d evictions, %0d re-attaches, %0d refused when full, %0d with nothing to evict",
			evictions, moved_to_mru, refused_full, nothing_to_evict);
		if (failures == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("timeout with %0d responses still outstanding", predicted_responses.size());
		$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
